// ===== design/ale_pkg.sv =====
// Shared types and constants for the array list engine.
`timescale 1ns / 1ps

package ale_pkg;

  localparam int DATA_W = 32;

  // Command codes
  localparam logic [2:0] KIND_CLEAR  = 3'd0;
  localparam logic [2:0] KIND_INSERT = 3'd1;
  localparam logic [2:0] KIND_DELETE = 3'd2;
  localparam logic [2:0] KIND_FIND   = 3'd3;
  localparam logic [2:0] KIND_EXTREM = 3'd4;
  localparam logic [2:0] KIND_SORT   = 3'd5;

  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    logic [2:0]               kind;
    logic signed [DATA_W-1:0] value;
    logic [7:0]               position;
    logic                     ascending;
  } in_t;

  typedef struct packed {
    logic                     status;
    logic signed [DATA_W-1:0] removed_value;
    logic                     found;
    logic [6:0]               found_position;
    logic signed [DATA_W-1:0] max_value;
    logic signed [DATA_W-1:0] min_value;
    logic [7:0]               length;
    logic                     is_empty;
    logic                     is_full;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS,
    S_INS_PUT,
    S_DEL,
    S_FIND,
    S_EXT,
    S_SKEY,
    S_SKW,
    S_SCMP,
    S_SPUT,
    S_DONE
  } state_t;

endpackage

// ===== design/ale_ram.sv =====
// Entry store: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module ale_ram #(
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [ale_pkg::DATA_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [ale_pkg::DATA_W-1:0] rdata
);

  logic [ale_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/array_list_engine.sv =====
// Top level of the array list engine: command sequencer around the entry store.
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY_MAX signed 32-bit values, one command at a time.
// Input channel (in_valid/in_stall/in_data) carries clear, insert, delete, find,
// extremes and sort commands; output channel (out_valid/out_stall/out_data)
// returns exactly one result transaction per command with status, length and
// the empty/full flags after the command.
// Entries sit in a single RAM with one read and one write per cycle and
// registered read data. Clear, find on an empty list, sort of 0 or 1
// entries and rejected or unknown commands read no entries, and append at
// the end writes its entry without shifting. Insert walks down from the last
// entry to the position, moving each entry up by one; delete walks up from
// the position to the last entry, moving each entry down by one; find reads
// from the first entry and stops at the first hit; extremes reads every
// entry; sort is an insertion sort.
// in_stall is high while a command is in progress and during reset; one
// finished result can wait in the output register while the next command is
// taken. If out_stall holds a result, the following command completes
// internally and then waits until the output register frees up.
// Reset (rst_n low, synchronous) empties the list; stored entries are not
// cleared since only positions below the length are ever read.

module array_list_engine #(
  parameter int CAPACITY_MAX = 128
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ale_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ale_pkg::out_t out_data
);

  localparam int AW    = $clog2(CAPACITY_MAX);
  localparam int CNT_W = $clog2(CAPACITY_MAX + 1);
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
  localparam int DW    = ale_pkg::DATA_W;

  // Control state
  ale_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             iss_r, iss_nxt;     // streaming reads still to issue
  logic             rvld_r;             // read data valid this cycle
  logic             out_valid_r;

  // Command and walk payload
  logic [DW-1:0]    val_r, val_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic             up_r, up_nxt;
  logic [AW-1:0]    nxt_r, nxt_nxt;     // next stream read address
  logic [AW-1:0]    end_r, end_nxt;     // last stream read address
  logic [AW-1:0]    raddr_q_r;          // address of data in rdata
  logic [AW-1:0]    i_r, i_nxt;         // sort: outer index
  logic [AW-1:0]    j_r, j_nxt;         // sort: hole position
  logic [DW-1:0]    key_r, key_nxt;

  // Result accumulators
  logic             status_r, status_nxt;
  logic [DW-1:0]    removed_r, removed_nxt;
  logic             found_r, found_nxt;
  logic [AW-1:0]    fpos_r, fpos_nxt;
  logic [DW-1:0]    max_r, max_nxt;
  logic [DW-1:0]    min_r, min_nxt;
  ale_pkg::out_t    out_data_r;

  // RAM ports
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [DW-1:0]    rdata;
  logic             we;
  logic [AW-1:0]    wa;
  logic [DW-1:0]    wd;

  logic             in_acc;
  logic             load_out;
  logic [CMP_W-1:0] pos_w, cnt_w;
  logic [AW-1:0]    cnt_m1;
  logic             is_full, is_empty;
  logic             move;

  ale_ram #(
    .DEPTH (CAPACITY_MAX)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wa),
    .wdata (wd),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign in_stall  = (state_r != ale_pkg::S_IDLE) || !rst_n;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign pos_w    = CMP_W'(in_data.position);
  assign cnt_w    = CMP_W'(cnt_r);
  assign cnt_m1   = AW'(cnt_r - CNT_W'(1));
  assign is_full  = (cnt_r == CNT_W'(CAPACITY_MAX));
  assign is_empty = (cnt_r == '0);

  // Sort shift test: key still belongs below the entry read
  assign move = up_r ? ($signed(key_r) < $signed(rdata))
                     : ($signed(rdata) < $signed(key_r));

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    iss_nxt     = iss_r;
    val_nxt     = val_r;
    pos_nxt     = pos_r;
    up_nxt      = up_r;
    nxt_nxt     = nxt_r;
    end_nxt     = end_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    key_nxt     = key_r;
    status_nxt  = status_r;
    removed_nxt = removed_r;
    found_nxt   = found_r;
    fpos_nxt    = fpos_r;
    max_nxt     = max_r;
    min_nxt     = min_r;
    rd_en       = 1'b0;
    rd_addr     = nxt_r;
    we          = 1'b0;
    wa          = raddr_q_r;
    wd          = rdata;
    load_out    = 1'b0;

    // Streaming walks issue one read per cycle from nxt_r toward end_r
    if (state_r inside {ale_pkg::S_INS, ale_pkg::S_DEL, ale_pkg::S_FIND,
                        ale_pkg::S_EXT}) begin
      rd_en = iss_r;
      if (iss_r) begin
        iss_nxt = (nxt_r != end_r);
        nxt_nxt = (state_r == ale_pkg::S_INS) ? nxt_r - AW'(1) : nxt_r + AW'(1);
      end
    end

    case (state_r)
      ale_pkg::S_IDLE: begin
        if (in_acc) begin
          val_nxt     = in_data.value;
          pos_nxt     = AW'(in_data.position);
          up_nxt      = in_data.ascending;
          status_nxt  = ale_pkg::STATUS_DONE;
          removed_nxt = '0;
          found_nxt   = 1'b0;
          fpos_nxt    = '0;
          max_nxt     = '0;
          min_nxt     = '0;
          state_nxt   = ale_pkg::S_DONE;
          case (in_data.kind)
            ale_pkg::KIND_CLEAR: begin
              cnt_nxt = '0;
            end
            ale_pkg::KIND_INSERT: begin
              if (is_full || (pos_w > cnt_w)) begin
                status_nxt = ale_pkg::STATUS_REJECT;
              end else if (pos_w == cnt_w) begin
                // append: no shifting
                we      = 1'b1;
                wa      = AW'(in_data.position);
                wd      = in_data.value;
                cnt_nxt = cnt_r + CNT_W'(1);
              end else begin
                iss_nxt   = 1'b1;
                nxt_nxt   = cnt_m1;
                end_nxt   = AW'(in_data.position);
                state_nxt = ale_pkg::S_INS;
              end
            end
            ale_pkg::KIND_DELETE: begin
              if (is_empty || (pos_w >= cnt_w)) begin
                status_nxt = ale_pkg::STATUS_REJECT;
              end else begin
                iss_nxt   = 1'b1;
                nxt_nxt   = AW'(in_data.position);
                end_nxt   = cnt_m1;
                state_nxt = ale_pkg::S_DEL;
              end
            end
            ale_pkg::KIND_FIND: begin
              if (!is_empty) begin
                iss_nxt   = 1'b1;
                nxt_nxt   = '0;
                end_nxt   = cnt_m1;
                state_nxt = ale_pkg::S_FIND;
              end
            end
            ale_pkg::KIND_EXTREM: begin
              if (is_empty) begin
                status_nxt = ale_pkg::STATUS_REJECT;
              end else begin
                iss_nxt   = 1'b1;
                nxt_nxt   = '0;
                end_nxt   = cnt_m1;
                state_nxt = ale_pkg::S_EXT;
              end
            end
            ale_pkg::KIND_SORT: begin
              if (cnt_r > CNT_W'(1)) begin
                i_nxt     = AW'(1);
                state_nxt = ale_pkg::S_SKEY;
              end
            end
            default: begin
              status_nxt = ale_pkg::STATUS_REJECT;
            end
          endcase
        end
      end

      ale_pkg::S_INS: begin
        // move entry up by one, walking down to the insert position
        if (rvld_r) begin
          we = 1'b1;
          wa = raddr_q_r + AW'(1);
          if (raddr_q_r == pos_r) begin
            state_nxt = ale_pkg::S_INS_PUT;
          end
        end
      end

      ale_pkg::S_INS_PUT: begin
        we        = 1'b1;
        wa        = pos_r;
        wd        = val_r;
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = ale_pkg::S_DONE;
      end

      ale_pkg::S_DEL: begin
        if (rvld_r) begin
          if (raddr_q_r == pos_r) begin
            removed_nxt = rdata;
          end else begin
            we = 1'b1;
            wa = raddr_q_r - AW'(1);
          end
          if (raddr_q_r == end_r) begin
            cnt_nxt   = cnt_r - CNT_W'(1);
            state_nxt = ale_pkg::S_DONE;
          end
        end
      end

      ale_pkg::S_FIND: begin
        if (rvld_r) begin
          if (rdata == val_r) begin
            found_nxt = 1'b1;
            fpos_nxt  = raddr_q_r;
            iss_nxt   = 1'b0;
            state_nxt = ale_pkg::S_DONE;
          end else if (raddr_q_r == end_r) begin
            state_nxt = ale_pkg::S_DONE;
          end
        end
      end

      ale_pkg::S_EXT: begin
        if (rvld_r) begin
          if (raddr_q_r == '0) begin
            max_nxt = rdata;
            min_nxt = rdata;
          end else begin
            if ($signed(max_r) < $signed(rdata)) begin
              max_nxt = rdata;
            end
            if ($signed(rdata) < $signed(min_r)) begin
              min_nxt = rdata;
            end
          end
          if (raddr_q_r == end_r) begin
            state_nxt = ale_pkg::S_DONE;
          end
        end
      end

      ale_pkg::S_SKEY: begin
        rd_en     = 1'b1;
        rd_addr   = i_r;
        state_nxt = ale_pkg::S_SKW;
      end

      ale_pkg::S_SKW: begin
        key_nxt   = rdata;
        j_nxt     = i_r;
        rd_en     = 1'b1;
        rd_addr   = i_r - AW'(1);
        state_nxt = ale_pkg::S_SCMP;
      end

      ale_pkg::S_SCMP: begin
        // rdata holds entry j-1
        we = 1'b1;
        wa = j_r;
        if (move) begin
          wd    = rdata;
          j_nxt = j_r - AW'(1);
          if (j_r == AW'(1)) begin
            state_nxt = ale_pkg::S_SPUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = j_r - AW'(2);
          end
        end else begin
          wd = key_r;
          if (i_r == cnt_m1) begin
            state_nxt = ale_pkg::S_DONE;
          end else begin
            i_nxt     = i_r + AW'(1);
            state_nxt = ale_pkg::S_SKEY;
          end
        end
      end

      ale_pkg::S_SPUT: begin
        we = 1'b1;
        wa = j_r;
        wd = key_r;
        if (i_r == cnt_m1) begin
          state_nxt = ale_pkg::S_DONE;
        end else begin
          i_nxt     = i_r + AW'(1);
          state_nxt = ale_pkg::S_SKEY;
        end
      end

      ale_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ale_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ale_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ale_pkg::S_IDLE;
      cnt_r       <= '0;
      iss_r       <= 1'b0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      iss_r       <= iss_nxt;
      rvld_r      <= rd_en;
      out_valid_r <= load_out || (out_valid_r && out_stall);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    val_r     <= val_nxt;
    pos_r     <= pos_nxt;
    up_r      <= up_nxt;
    nxt_r     <= nxt_nxt;
    end_r     <= end_nxt;
    raddr_q_r <= rd_addr;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    key_r     <= key_nxt;
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
    found_r   <= found_nxt;
    fpos_r    <= fpos_nxt;
    max_r     <= max_nxt;
    min_r     <= min_nxt;
    if (load_out) begin
      out_data_r.status         <= status_r;
      out_data_r.removed_value  <= removed_r;
      out_data_r.found          <= found_r;
      out_data_r.found_position <= 7'(fpos_r);
      out_data_r.max_value      <= max_r;
      out_data_r.min_value      <= min_r;
      out_data_r.length         <= 8'(cnt_r);
      out_data_r.is_empty       <= is_empty;
      out_data_r.is_full        <= is_full;
    end
  end

  // Checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY_MAX))
    else $error("entry count above capacity");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (we && rd_en) |-> (wa != rd_addr))
    else $error("read and write of the same entry in one cycle");

  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (we |-> ({1'b0, wa} < (AW+1)'(CAPACITY_MAX))) and
    (rd_en |-> ({1'b0, rd_addr} < (AW+1)'(CAPACITY_MAX))))
    else $error("RAM address beyond capacity");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ale_pkg::S_DONE && !(out_valid_r && out_stall)) |=>
      (out_valid_r && state_r == ale_pkg::S_IDLE))
    else $error("finished command did not reach the output register");

endmodule
